### rtl/aes_pkg.sv
// Shared types, S-box tables and round functions for the AES-128 block cipher.
// Has no dependencies; every other file in rtl/ uses it.
`default_nettype none

package aes_pkg;

   localparam int ROUNDS_DEFAULT = 10;
   localparam int BLOCK_BITS     = 128;
   localparam int KEY_BITS       = 128;

   typedef struct packed {
      logic        mode;
      logic [63:0] data_low;
      logic [63:0] data_high;
   } req_type;

   typedef struct packed {
      logic [63:0] result_low;
      logic [63:0] result_high;
   } rsp_type;

   // Control that travels alongside one block through a stage.
   typedef struct packed {
      logic valid;
      logic mode;
   } stage_ctl_type;

   typedef logic [7:0] sbox_table_type [256];

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = '0;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ x;
         x = xtime(x);
      end
      return p;
   endfunction

   function automatic logic [7:0] ginv(input logic [7:0] x);
      logic [7:0] p;
      logic [7:0] base;
      logic [7:0] e;
      p    = 8'h01;
      base = x;
      e    = 8'd254;
      for (int i = 0; i < 8; i++) begin
         if (e[i]) p = gmul(p, base);
         base = gmul(base, base);
      end
      return p;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
      return (v << n) | (v >> (8 - n));
   endfunction

   // Tables are built at elaboration from the field inverse and the affine map.
   function automatic sbox_table_type gen_sbox(input logic inverse);
      sbox_table_type t;
      logic [7:0] x;
      logic [7:0] b;
      for (int i = 0; i < 256; i++) begin
         x = i[7:0];
         if (!inverse) begin
            b = ginv(x);
            t[i] = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
         end else begin
            b = rotl8(x, 1) ^ rotl8(x, 3) ^ rotl8(x, 6) ^ 8'h05;
            t[i] = ginv(b);
         end
      end
      return t;
   endfunction

   localparam sbox_table_type SBOX     = gen_sbox(1'b0);
   localparam sbox_table_type INV_SBOX = gen_sbox(1'b1);

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      logic [31:0] r;
      for (int k = 0; k < 4; k++) r[8*k +: 8] = SBOX[w[8*k +: 8]];
      return r;
   endfunction

   function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inverse);
      logic [127:0] t;
      for (int j = 0; j < 16; j++)
         t[8*j +: 8] = inverse ? INV_SBOX[s[8*j +: 8]] : SBOX[s[8*j +: 8]];
      return t;
   endfunction

   // State byte j is row j%4, column j/4.
   function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inverse);
      logic [127:0] t;
      t = '0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (!inverse) t[8*(r + 4*c) +: 8] = s[8*(r + 4*((c + r) % 4)) +: 8];
            else          t[8*(r + 4*((c + r) % 4)) +: 8] = s[8*(r + 4*c) +: 8];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inverse);
      logic [127:0] t;
      logic [7:0]   a [4];
      logic [7:0]   x2 [4];
      logic [7:0]   x4 [4];
      logic [7:0]   x8 [4];
      logic [7:0]   m [4];
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            a[k]  = s[8*(4*c + k) +: 8];
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
         end
         for (int r = 0; r < 4; r++) begin
            for (int k = 0; k < 4; k++) begin
               case (k)
                  0: m[k] = inverse ? (x8[(r+k)%4] ^ x4[(r+k)%4] ^ x2[(r+k)%4])
                                    : x2[(r+k)%4];
                  1: m[k] = inverse ? (x8[(r+k)%4] ^ x2[(r+k)%4] ^ a[(r+k)%4])
                                    : (x2[(r+k)%4] ^ a[(r+k)%4]);
                  2: m[k] = inverse ? (x8[(r+k)%4] ^ x4[(r+k)%4] ^ a[(r+k)%4])
                                    : a[(r+k)%4];
                  default: m[k] = inverse ? (x8[(r+k)%4] ^ a[(r+k)%4]) : a[(r+k)%4];
               endcase
            end
            t[8*(4*c + r) +: 8] = m[0] ^ m[1] ^ m[2] ^ m[3];
         end
      end
      return t;
   endfunction

endpackage

`default_nettype wire

### rtl/aes_key_expand.sv
// Sequential AES-128 key schedule: one round key per clock after a start.
// Depends on aes_pkg.
`default_nettype none

module aes_key_expand #(
   parameter int ROUNDS = aes_pkg::ROUNDS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [aes_pkg::KEY_BITS-1:0]          key,
   output logic                                       busy,
   output logic [ROUNDS:0][aes_pkg::KEY_BITS-1:0]     round_keys
);

   localparam int CNT_W = $clog2(ROUNDS + 1);

   logic [ROUNDS:0][aes_pkg::KEY_BITS-1:0] rk_ff;
   logic [aes_pkg::KEY_BITS-1:0] prev_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic                         busy_ff;
   logic [7:0]                   rc_ff;
   logic [aes_pkg::KEY_BITS-1:0] next_in;
   logic [31:0]                  t;

   always_comb begin
      t = aes_pkg::sub_word({prev_ff[103:96], prev_ff[127:104]}) ^ {24'd0, rc_ff};
      next_in[31:0]   = prev_ff[31:0]   ^ t;
      next_in[63:32]  = prev_ff[63:32]  ^ next_in[31:0];
      next_in[95:64]  = prev_ff[95:64]  ^ next_in[63:32];
      next_in[127:96] = prev_ff[127:96] ^ next_in[95:64];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(1);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ROUNDS)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prev_ff  <= key;
         rk_ff[0] <= key;
         rc_ff    <= 8'h01;
      end else if (busy_ff) begin
         prev_ff        <= next_in;
         rk_ff[cnt_ff]  <= next_in;
         rc_ff          <= aes_pkg::xtime(rc_ff);
      end
   end

   assign busy       = busy_ff;
   assign round_keys = rk_ff;

endmodule

`default_nettype wire

### rtl/aes_round.sv
// One registered AES round stage serving both encryption and decryption.
// Depends on aes_pkg.
`default_nettype none

module aes_round #(
   parameter bit IS_LAST = 1'b0
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           load,
   input  wire aes_pkg::stage_ctl_type         in_ctl,
   input  wire logic [aes_pkg::BLOCK_BITS-1:0] in_state,
   input  wire logic [aes_pkg::KEY_BITS-1:0]   key_enc,
   input  wire logic [aes_pkg::KEY_BITS-1:0]   key_dec,
   output aes_pkg::stage_ctl_type              out_ctl,
   output logic [aes_pkg::BLOCK_BITS-1:0]      out_state
);

   aes_pkg::stage_ctl_type          ctl_ff;
   logic [aes_pkg::BLOCK_BITS-1:0]  state_ff;
   logic [aes_pkg::BLOCK_BITS-1:0]  shifted;
   logic [aes_pkg::BLOCK_BITS-1:0]  enc_mixed;
   logic [aes_pkg::BLOCK_BITS-1:0]  dec_keyed;
   logic [aes_pkg::BLOCK_BITS-1:0]  state_in;

   // Substitution and row shift commute, so both directions share this order.
   always_comb begin
      shifted   = aes_pkg::shift_rows(aes_pkg::sub_bytes(in_state, in_ctl.mode), in_ctl.mode);
      enc_mixed = IS_LAST ? shifted : aes_pkg::mix_columns(shifted, 1'b0);
      dec_keyed = shifted ^ key_dec;
      if (in_ctl.mode) state_in = IS_LAST ? dec_keyed : aes_pkg::mix_columns(dec_keyed, 1'b1);
      else             state_in = enc_mixed ^ key_enc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (load) begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         state_ff <= state_in;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_state = state_ff;

endmodule

`default_nettype wire

### rtl/aes128_block_cipher.sv
// AES-128 block cipher top level: configuration registers and the round pipeline.
// Depends on aes_pkg, aes_key_expand and aes_round.
`default_nettype none

// The block encrypts (mode 0) or decrypts (mode 1) one 128-bit block per
// transfer. It is a fully unrolled pipeline of ROUNDS + 1 register stages:
// an initial key-add stage and one stage per round. A new block can enter
// every cycle while the output does not stall and no key schedule runs.
// Each stage holds its block until the next stage can take it, so a stalled
// output fills the pipeline before the input stalls.
// The key is written through the APB port as key_low at address 0 and
// key_high at address 8. Every key write, and reset, starts a key schedule
// run that computes one round key per cycle; the input stalls from the write
// or reset until the run ends. The key must only be written while
// no block is in the pipeline.
module aes128_block_cipher #(
   parameter int ROUNDS = aes_pkg::ROUNDS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire aes_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output aes_pkg::rsp_type      rsp_data,
   input  wire logic             psel,
   input  wire logic             penable,
   input  wire logic             pwrite,
   input  wire logic [3:0]       paddr,
   input  wire logic [63:0]      pwdata,
   output logic [63:0]           prdata,
   output logic                  pready
);

   localparam logic REG_KEY_LOW  = 1'b0;
   localparam logic REG_KEY_HIGH = 1'b1;

   logic [63:0] key_low_ff;
   logic [63:0] key_high_ff;
   logic        start_ff;
   logic        csr_write;
   logic        key_busy;
   logic        accept;

   logic [ROUNDS:0][aes_pkg::KEY_BITS-1:0] round_keys;

   aes_pkg::stage_ctl_type                 ctl   [ROUNDS+1];
   logic [aes_pkg::BLOCK_BITS-1:0]         state [ROUNDS+1];
   logic [ROUNDS+1:0]                      ready;

   aes_pkg::stage_ctl_type                 ctl0_ff;
   logic [aes_pkg::BLOCK_BITS-1:0]         state0_ff;
   logic [aes_pkg::BLOCK_BITS-1:0]         block_in;

   // Configuration port. The address bit that selects the register is bit 3.
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign prdata    = (paddr[3] == REG_KEY_HIGH) ? key_high_ff : key_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         start_ff    <= 1'b1;
      end else begin
         start_ff <= 1'b0;
         if (csr_write && paddr[3] == REG_KEY_LOW)  key_low_ff  <= pwdata;
         if (csr_write && paddr[3] == REG_KEY_HIGH) key_high_ff <= pwdata;
      end
   end

   // The schedule starts on the cycle after a write, once the register holds
   // the new key; the start after reset uses the cleared key.
   logic write_seen_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         write_seen_ff <= 1'b0;
      end else begin
         write_seen_ff <= csr_write;
      end
   end

   aes_key_expand #(
      .ROUNDS(ROUNDS)
   ) u_key_expand (
      .clock      (clock),
      .reset      (reset),
      .start      (start_ff | write_seen_ff),
      .key        ({key_high_ff, key_low_ff}),
      .busy       (key_busy),
      .round_keys (round_keys)
   );

   // A stage can load when it is empty or when the stage after it loads.
   always_comb begin
      ready[ROUNDS+1] = ~rsp_stall;
      for (int i = ROUNDS; i >= 0; i--) ready[i] = ~ctl[i].valid | ready[i+1];
   end

   assign req_stall = ~ready[0] | key_busy | start_ff | write_seen_ff | csr_write;
   assign accept    = req_valid & ~req_stall;

   // Stage 0: initial round key add; decryption starts from the last round key.
   assign block_in = {req_data.data_high, req_data.data_low};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff <= '0;
      end else if (ready[0]) begin
         ctl0_ff.valid <= accept;
         ctl0_ff.mode  <= req_data.mode;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         state0_ff <= block_in ^ (req_data.mode ? round_keys[ROUNDS] : round_keys[0]);
      end
   end

   assign ctl[0]   = ctl0_ff;
   assign state[0] = state0_ff;

   for (genvar g = 1; g <= ROUNDS; g++) begin : g_round
      aes_round #(
         .IS_LAST(g == ROUNDS)
      ) u_round (
         .clock     (clock),
         .reset     (reset),
         .load      (ready[g]),
         .in_ctl    (ctl[g-1]),
         .in_state  (state[g-1]),
         .key_enc   (round_keys[g]),
         .key_dec   (round_keys[ROUNDS-g]),
         .out_ctl   (ctl[g]),
         .out_state (state[g])
      );
   end

   assign rsp_valid            = ctl[ROUNDS].valid;
   assign rsp_data.result_low  = state[ROUNDS][63:0];
   assign rsp_data.result_high = state[ROUNDS][127:64];

endmodule

`default_nettype wire
